@@ rtl/assert_macros.svh @@
// Assertion macros shared by the semaphore table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define SEMTAB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define SEMTAB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/semtab_pkg.sv @@
// Types and constants shared by the semaphore table modules.
`default_nettype none

package semtab_pkg;

  // Request operation codes
  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_WAIT   = 2'd1,
    CMD_SIGNAL = 2'd2,
    CMD_NOP    = 2'd3
  } semtab_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_QUEUE_FULL = 2'd2
  } semtab_status_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_FETCH = 2'd1,
    S_EXEC  = 2'd2
  } semtab_state_t;

  // Semaphore count format
  localparam int CNT_W = 16;
  localparam logic signed [CNT_W-1:0] CNT_MIN = 16'sh8000;
  localparam logic signed [CNT_W-1:0] CNT_MAX = 16'sh7FFF;

  // Free-entry search groups
  localparam int GROUP_SIZE = 16;
  localparam int GROUP_BITS = 4;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;    // latch the incoming request
    logic hold_addr;  // address memories from the latched request
    logic exec;       // write back and load the result register
  } semtab_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // result register can take a new result
  } semtab_sts_t;

endpackage

`default_nettype wire

@@ rtl/semtab_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module semtab_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write one entry, read one entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/semtab_ctrl.sv @@
// Controller state machine sequencing fetch, ring read and write-back.
`default_nettype none

module semtab_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire semtab_pkg::semtab_sts_t sts,
  output semtab_pkg::semtab_cmd_t      cmd
);

  semtab_pkg::semtab_state_t state_r;
  semtab_pkg::semtab_state_t state_nxt;

  // Advance the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= semtab_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      semtab_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = semtab_pkg::S_FETCH;
        end
      end
      semtab_pkg::S_FETCH: begin
        state_nxt = semtab_pkg::S_EXEC;
      end
      semtab_pkg::S_EXEC: begin
        if (sts.out_free) begin
          state_nxt = semtab_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = semtab_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.hold_addr = 1'b1;
    cmd.exec      = 1'b0;
    case (state_r)
      semtab_pkg::S_IDLE: begin
        in_ready      = 1'b1;
        cmd.capture   = in_valid;
        cmd.hold_addr = 1'b0;
      end
      semtab_pkg::S_FETCH: begin
        cmd.hold_addr = 1'b1;
      end
      semtab_pkg::S_EXEC: begin
        cmd.exec = sts.out_free;
      end
      default: begin
        cmd.hold_addr = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/semtab_dp.sv @@
// Datapath: request latch, free search, count and ring memories, result register.
`default_nettype none

module semtab_dp #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int PROC_BITS   = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire semtab_pkg::semtab_cmd_t cmd,
  output semtab_pkg::semtab_sts_t      sts,
  input  wire logic [1:0]              in_cmd,
  input  wire logic [7:0]              in_proc_id,
  input  wire logic [3:0]              in_sem_id,
  input  wire logic signed [15:0]      in_init_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   out_status,
  output logic [3:0]                   out_alloc_id,
  output logic                         out_caller_blocked,
  output logic                         out_wake_valid,
  output logic [7:0]                   out_wake_proc
);

  localparam int SB    = $clog2(NUM_SEMS);
  localparam int QB    = $clog2(QUEUE_DEPTH);
  localparam int FB    = $clog2(QUEUE_DEPTH + 1);
  localparam int WDEP  = NUM_SEMS * QUEUE_DEPTH;
  localparam int WA    = $clog2(WDEP);
  localparam int CW    = semtab_pkg::CNT_W;
  localparam int PTR_W = CW + QB + QB + FB;
  localparam int GS    = semtab_pkg::GROUP_SIZE;
  localparam int NG    = (NUM_SEMS + GS - 1) / GS;

  // Latched request
  logic [1:0]           cmd_r;
  logic [7:0]           proc_r;
  logic [3:0]           sem_r;
  logic signed [CW-1:0] init_r;

  // Allocation flags and free-entry search
  logic [NUM_SEMS-1:0]                  in_use_r;
  logic [NG*GS-1:0]                     used_pad;
  logic [NG-1:0]                        grp_any_r;
  logic [NG-1:0]                        grp_any_nxt;
  logic [semtab_pkg::GROUP_BITS-1:0]    grp_idx_r   [NG];
  logic [semtab_pkg::GROUP_BITS-1:0]    grp_idx_nxt [NG];
  logic                                 free_found;
  logic [15:0]                          alloc_wide;
  logic [SB-1:0]                        alloc_idx;

  // Memory ports
  logic [3:0]       addr_sem;
  logic [15:0]      addr_wide;
  logic [15:0]      sem_wide;
  logic [SB-1:0]    sem_idx;
  logic             ptr_we;
  logic [SB-1:0]    ptr_waddr;
  logic [PTR_W-1:0] ptr_wdata;
  logic [PTR_W-1:0] ptr_rdata;
  logic             wtr_we;
  logic [WA-1:0]    wtr_waddr;
  logic [WA-1:0]    wtr_raddr;
  logic [PROC_BITS-1:0] wtr_wdata;
  logic [PROC_BITS-1:0] wtr_rdata;
  logic [31:0]      wtr_rsum;
  logic [31:0]      wtr_wsum;
  logic [23:0]      proc_wide;
  logic [23:0]      wake_wide;

  // Fields of the fetched pointer word
  logic signed [CW-1:0] cnt;
  logic [QB-1:0]        head;
  logic [QB-1:0]        tail;
  logic [FB-1:0]        fill;
  logic signed [CW-1:0] cnt_nxt;
  logic [QB-1:0]        head_nxt;
  logic [QB-1:0]        tail_nxt;
  logic [FB-1:0]        fill_nxt;
  logic                 sem_ok;

  // Result
  logic       out_valid_r;
  logic [1:0] status_r;
  logic [1:0] status_nxt;
  logic [3:0] alloc_r;
  logic [3:0] alloc_nxt;
  logic       blocked_r;
  logic       blocked_nxt;
  logic       wv_r;
  logic       wv_nxt;
  logic [7:0] wp_r;
  logic [7:0] wp_nxt;

  // Latch the request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_cmd;
      proc_r <= in_proc_id;
      sem_r  <= in_sem_id;
      init_r <= in_init_value;
    end
  end

  // Per-group lowest free entry
  always_comb begin
    used_pad = '1;
    used_pad[NUM_SEMS-1:0] = in_use_r;
    for (int g = 0; g < NG; g++) begin
      grp_any_nxt[g] = 1'b0;
      grp_idx_nxt[g] = '0;
      for (int k = GS - 1; k >= 0; k--) begin
        if (!used_pad[g*GS + k]) begin
          grp_any_nxt[g] = 1'b1;
          grp_idx_nxt[g] = semtab_pkg::GROUP_BITS'(k);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_any_r <= grp_any_nxt;
    grp_idx_r <= grp_idx_nxt;
  end

  // Lowest free group
  always_comb begin
    free_found = 1'b0;
    alloc_wide = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_any_r[g]) begin
        free_found = 1'b1;
        alloc_wide = 16'(g * GS) + 16'(grp_idx_r[g]);
      end
    end
    alloc_idx = alloc_wide[SB-1:0];
  end

  // Address the pointer memory from the port while idle, else from the latched request
  assign addr_sem  = cmd.hold_addr ? sem_r : in_sem_id;
  assign addr_wide = 16'(addr_sem);
  assign sem_wide  = 16'(sem_r);
  assign sem_idx   = sem_wide[SB-1:0];

  // Unpack the pointer word
  assign {cnt, head, tail, fill} = ptr_rdata;

  // Ring slot addresses
  assign wtr_rsum  = 32'(sem_idx) * 32'(QUEUE_DEPTH) + 32'(head);
  assign wtr_wsum  = 32'(sem_idx) * 32'(QUEUE_DEPTH) + 32'(tail);
  assign wtr_raddr = wtr_rsum[WA-1:0];
  assign wtr_waddr = wtr_wsum[WA-1:0];
  assign proc_wide = 24'(proc_r);
  assign wtr_wdata = proc_wide[PROC_BITS-1:0];
  assign wake_wide = 24'(wtr_rdata);

  assign sem_ok = (sem_wide < 16'(NUM_SEMS)) && in_use_r[sem_idx];

  // Execute the request
  always_comb begin
    cnt_nxt     = cnt;
    head_nxt    = head;
    tail_nxt    = tail;
    fill_nxt    = fill;
    ptr_we      = 1'b0;
    ptr_waddr   = sem_idx;
    wtr_we      = 1'b0;
    status_nxt  = semtab_pkg::STAT_OK;
    alloc_nxt   = '0;
    blocked_nxt = 1'b0;
    wv_nxt      = 1'b0;
    wp_nxt      = '0;
    case (cmd_r)
      semtab_pkg::CMD_ALLOC: begin
        if (free_found) begin
          ptr_we    = cmd.exec;
          ptr_waddr = alloc_idx;
          cnt_nxt   = init_r;
          head_nxt  = '0;
          tail_nxt  = '0;
          fill_nxt  = '0;
          alloc_nxt = alloc_wide[3:0];
        end else begin
          status_nxt = semtab_pkg::STAT_NO_FREE;
        end
      end
      semtab_pkg::CMD_WAIT: begin
        if (sem_ok) begin
          if (cnt > 16'sd0) begin
            ptr_we  = cmd.exec;
            cnt_nxt = cnt - 16'sd1;
          end else if (cnt == semtab_pkg::CNT_MIN || fill >= FB'(QUEUE_DEPTH)) begin
            status_nxt = semtab_pkg::STAT_QUEUE_FULL;
          end else begin
            ptr_we      = cmd.exec;
            wtr_we      = cmd.exec;
            cnt_nxt     = cnt - 16'sd1;
            tail_nxt    = (tail == QB'(QUEUE_DEPTH - 1)) ? '0 : tail + 1'b1;
            fill_nxt    = fill + 1'b1;
            blocked_nxt = 1'b1;
          end
        end
      end
      semtab_pkg::CMD_SIGNAL: begin
        if (sem_ok) begin
          ptr_we = cmd.exec;
          if (cnt != semtab_pkg::CNT_MAX) begin
            cnt_nxt = cnt + 16'sd1;
          end
          if (cnt < 16'sd0 && fill != '0) begin
            head_nxt = (head == QB'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
            fill_nxt = fill - 1'b1;
            wv_nxt   = 1'b1;
            wp_nxt   = wake_wide[7:0];
          end
        end
      end
      default: begin
        status_nxt = semtab_pkg::STAT_OK;
      end
    endcase
    ptr_wdata = {cnt_nxt, head_nxt, tail_nxt, fill_nxt};
  end

  // Mark the claimed entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cmd.exec && cmd_r == semtab_pkg::CMD_ALLOC && free_found) begin
      in_use_r[alloc_idx] <= 1'b1;
    end
  end

  // Count and ring pointers, one word per semaphore
  semtab_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_SEMS)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (ptr_waddr),
    .wdata (ptr_wdata),
    .raddr (addr_wide[SB-1:0]),
    .rdata (ptr_rdata)
  );

  // Wait rings, QUEUE_DEPTH slots per semaphore
  semtab_ram #(
    .WIDTH (PROC_BITS),
    .DEPTH (WDEP)
  ) u_wtr_ram (
    .clk   (clk),
    .we    (wtr_we),
    .waddr (wtr_waddr),
    .wdata (wtr_wdata),
    .raddr (wtr_raddr),
    .rdata (wtr_rdata)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.exec) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r  <= status_nxt;
      alloc_r   <= alloc_nxt;
      blocked_r <= blocked_nxt;
      wv_r      <= wv_nxt;
      wp_r      <= wp_nxt;
    end
  end

  assign sts.out_free       = !out_valid_r || out_ready;
  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_alloc_id       = alloc_r;
  assign out_caller_blocked = blocked_r;
  assign out_wake_valid     = wv_r;
  assign out_wake_proc      = wp_r;

endmodule

`default_nettype wire

@@ rtl/semaphore_table_with_wait_queues.sv @@
// Top level: counting-semaphore table with a FIFO wait ring per semaphore.
// An accepted request passes through pointer read, wait-ring read and write-back,
// and a further request is taken only after the write-back loads the result register;
//   a stalled result holds the write-back until the result register frees.
// Reset: clears the allocation flags, the controller and the result valid; count and ring
//   memories are not cleared: allocate writes the count word, and wait writes a ring slot before it is read.
`default_nettype none
`include "assert_macros.svh"

module semaphore_table_with_wait_queues #(
  parameter int NUM_SEMS    = 16,
  parameter int QUEUE_DEPTH = 16,
  parameter int PROC_BITS   = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [7:0]         in_proc_id,
  input  wire logic [3:0]         in_sem_id,
  input  wire logic signed [15:0] in_init_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic [3:0]              out_alloc_id,
  output logic                    out_caller_blocked,
  output logic                    out_wake_valid,
  output logic [7:0]              out_wake_proc
);

  semtab_pkg::semtab_cmd_t cmd;
  semtab_pkg::semtab_sts_t sts;

  // Sequence the request
  semtab_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Execute the request
  semtab_dp #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PROC_BITS   (PROC_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_proc_id         (in_proc_id),
    .in_sem_id          (in_sem_id),
    .in_init_value      (in_init_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_alloc_id       (out_alloc_id),
    .out_caller_blocked (out_caller_blocked),
    .out_wake_valid     (out_wake_valid),
    .out_wake_proc      (out_wake_proc)
  );

  // One request in flight at a time
  `SEMTAB_ASSERT_NEXT(a_one_in_flight, clk, rst_n, in_valid && in_ready, !in_ready, "request accepted while another is in flight")

  // Write-back only into a free result register
  `SEMTAB_ASSERT_SAME(a_exec_slot_free, clk, rst_n, cmd.exec, !out_valid || out_ready, "result register overwritten")

  // A result never both blocks and wakes
  `SEMTAB_ASSERT_SAME(a_block_xor_wake, clk, rst_n, out_valid, !(out_caller_blocked && out_wake_valid), "blocked and wake set together")

  // A failed allocate reports nothing else
  `SEMTAB_ASSERT_SAME(a_no_free_clean, clk, rst_n, out_valid && out_status == semtab_pkg::STAT_NO_FREE, out_alloc_id == 4'd0 && !out_wake_valid && !out_caller_blocked, "failed allocate carries other fields")

endmodule

`default_nettype wire
